[rtl/core/scancode_to_ascii_fifo_core_macros.svh]
// Assertion macros shared by the scancode translator RTL.
// Every macro samples on clock and is disabled while reset is high.
`ifndef SCANCODE_TO_ASCII_FIFO_CORE_MACROS_SVH
`define SCANCODE_TO_ASCII_FIFO_CORE_MACROS_SVH

// Same-cycle implication.
`define SCTA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication.
`define SCTA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[rtl/core/scta_pkg.sv]
// Shared types, constants and keymap tables for the scancode translator.
// No dependencies; imported by every module in rtl/core.
package scta_pkg;

   localparam int BUFFER_DEPTH = 256;
   localparam int PTR_W        = $clog2(BUFFER_DEPTH);
   localparam int CHAR_W       = 7;
   localparam int CODE_W       = 8;
   localparam int TABLE_SIZE   = 58;
   localparam int TIDX_W       = $clog2(TABLE_SIZE);

   localparam logic OP_SCANCODE = 1'b0;
   localparam logic OP_READ     = 1'b1;

   localparam logic [CODE_W-1:0] SC_LSHIFT_MAKE  = 8'h2A;
   localparam logic [CODE_W-1:0] SC_RSHIFT_MAKE  = 8'h36;
   localparam logic [CODE_W-1:0] SC_LSHIFT_BREAK = 8'hAA;
   localparam logic [CODE_W-1:0] SC_RSHIFT_BREAK = 8'hB6;
   localparam logic [CODE_W-1:0] SC_ALT_MAKE     = 8'h38;
   localparam logic [CODE_W-1:0] SC_ALT_BREAK    = 8'hB8;

   localparam logic [CHAR_W-1:0] PLAIN_MAP [TABLE_SIZE] = '{
      7'd0,   7'd27,  7'd49,  7'd50,  7'd51,  7'd52,  7'd53,  7'd54,  7'd55,  7'd56,
      7'd57,  7'd48,  7'd45,  7'd61,  7'd8,   7'd9,   7'd113, 7'd119, 7'd101, 7'd114,
      7'd116, 7'd121, 7'd117, 7'd105, 7'd111, 7'd112, 7'd91,  7'd93,  7'd10,  7'd0,
      7'd97,  7'd115, 7'd100, 7'd102, 7'd103, 7'd104, 7'd106, 7'd107, 7'd108, 7'd59,
      7'd39,  7'd96,  7'd0,   7'd92,  7'd122, 7'd120, 7'd99,  7'd118, 7'd98,  7'd110,
      7'd109, 7'd44,  7'd46,  7'd47,  7'd0,   7'd42,  7'd0,   7'd32
   };

   localparam logic [CHAR_W-1:0] SHIFTED_MAP [TABLE_SIZE] = '{
      7'd0,   7'd27,  7'd33,  7'd64,  7'd35,  7'd36,  7'd37,  7'd94,  7'd38,  7'd42,
      7'd40,  7'd41,  7'd95,  7'd43,  7'd8,   7'd9,   7'd81,  7'd87,  7'd69,  7'd82,
      7'd84,  7'd89,  7'd85,  7'd73,  7'd79,  7'd80,  7'd123, 7'd125, 7'd10,  7'd0,
      7'd65,  7'd83,  7'd68,  7'd70,  7'd71,  7'd72,  7'd74,  7'd75,  7'd76,  7'd58,
      7'd34,  7'd126, 7'd0,   7'd124, 7'd90,  7'd88,  7'd67,  7'd86,  7'd66,  7'd78,
      7'd77,  7'd60,  7'd62,  7'd63,  7'd0,   7'd42,  7'd0,   7'd32
   };

   // translator result for one scancode
   typedef struct packed {
      logic              push;
      logic [CHAR_W-1:0] ch;
   } xlate_type;

   // ring buffer status toward the result register
   typedef struct packed {
      logic pop;
      logic empty_next;
   } ring_status_type;

endpackage

[rtl/core/scta_xlate.sv]
// Set-1 scancode decoder: shift tracking and plain/shifted keymap lookup.
// Depends on scta_pkg.
module scta_xlate (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic                            opcode,
   input  logic [scta_pkg::CODE_W-1:0]     scancode,
   output scta_pkg::xlate_type             xlate
);
   import scta_pkg::*;

   logic              shift_ff;
   logic              shift_in;
   logic [CHAR_W-1:0] ch;
   logic              in_table;

   assign in_table = (scancode < CODE_W'(TABLE_SIZE));

   always_comb begin
      shift_in = shift_ff;
      ch       = '0;
      if (scancode == SC_LSHIFT_MAKE || scancode == SC_RSHIFT_MAKE) begin
         shift_in = 1'b1;
      end else if (scancode == SC_LSHIFT_BREAK || scancode == SC_RSHIFT_BREAK) begin
         shift_in = 1'b0;
      end else if (scancode == SC_ALT_MAKE || scancode == SC_ALT_BREAK) begin
         ch = '0;
      end else if (in_table) begin
         // break codes have bit 7 set and never pass the range check
         ch = shift_ff ? SHIFTED_MAP[scancode[TIDX_W-1:0]]
                       : PLAIN_MAP[scancode[TIDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
      end else if (accept && opcode == OP_SCANCODE) begin
         shift_ff <= shift_in;
      end
   end

   assign xlate.push = (opcode == OP_SCANCODE) && (ch != '0);
   assign xlate.ch   = ch;

endmodule

[rtl/core/scta_ring.sv]
// Character ring buffer: one memory, read and write positions, no full check.
// Depends on scta_pkg and the assertion macro header.
`include "scancode_to_ascii_fifo_core_macros.svh"
module scta_ring (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic                            opcode,
   input  scta_pkg::xlate_type             xlate,
   output scta_pkg::ring_status_type       status,
   output logic [scta_pkg::CHAR_W-1:0]     rdata
);
   import scta_pkg::*;

   logic [CHAR_W-1:0] char_mem [BUFFER_DEPTH];
   logic [CHAR_W-1:0] rdata_ff;
   logic [PTR_W-1:0]  rd_pos_ff, rd_pos_in;
   logic [PTR_W-1:0]  wr_pos_ff, wr_pos_in;
   logic              empty;
   logic              push;
   logic              pop;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] pos);
      return (pos == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : pos + 1'b1;
   endfunction

   assign empty = (rd_pos_ff == wr_pos_ff);
   assign push  = accept && xlate.push;
   assign pop   = accept && (opcode == OP_READ) && !empty;

   assign rd_pos_in = pop  ? advance(rd_pos_ff) : rd_pos_ff;
   assign wr_pos_in = push ? advance(wr_pos_ff) : wr_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pos_ff <= '0;
         wr_pos_ff <= '0;
      end else begin
         rd_pos_ff <= rd_pos_in;
         wr_pos_ff <= wr_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         char_mem[wr_pos_ff] <= xlate.ch;
      end
      if (pop) begin
         rdata_ff <= char_mem[rd_pos_ff];
      end
   end

   assign status.pop        = pop;
   assign status.empty_next = (rd_pos_in == wr_pos_in);
   assign rdata             = rdata_ff;

   `SCTA_ASSERT_NOW(a_no_push_and_pop, 1'b1, !(push && pop))
   `SCTA_ASSERT_NEXT(a_idle_holds_pos, !push && !pop,
                     rd_pos_ff == $past(rd_pos_ff) && wr_pos_ff == $past(wr_pos_ff))
   `SCTA_ASSERT_NEXT(a_pop_moves_rd, pop, rd_pos_ff != $past(rd_pos_ff))

endmodule

[rtl/core/scancode_to_ascii_fifo_core.sv]
// Top level of the set-1 scancode to ASCII translator with character buffer.
// Depends on scta_pkg, scta_xlate, scta_ring and the assertion macro header.
//
// Usage:
//  - req channel: req_opcode selects a scancode (req_scancode) or a read of
//    one buffered character. Every accepted request gives one rsp transfer.
//  - rsp channel: rsp_out_char is the echoed character of a translated key,
//    or the popped character of a read, else 0; rsp_out_valid flags it;
//    rsp_buffer_empty is the buffer state after the request.
//  - Response: presented in the cycle after the req transfer.
//  - Throughput: one request per cycle while no response is stalled; the
//    decode, keymap lookup and the buffer memory access all fit between the
//    request edge and the single result register, with the read data taken
//    from the memory's output register.
//  - Stall: while a response waits on rsp_ready low, req_ready is low and the
//    response register holds; req_ready returns as soon as it is taken.
//  - Reset (synchronous): clears the shift flag, both buffer positions and the
//    response valid. Buffer contents are not cleared; no clearing pass.
//  - The buffer has no full check: a push past a full buffer overwrites and
//    the buffer then reads as empty.
`include "scancode_to_ascii_fifo_core_macros.svh"
module scancode_to_ascii_fifo_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_opcode,
   input  logic [scta_pkg::CODE_W-1:0]     req_scancode,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [scta_pkg::CHAR_W-1:0]     rsp_out_char,
   output logic                            rsp_out_valid,
   output logic                            rsp_buffer_empty
);
   import scta_pkg::*;

   logic              accept;
   xlate_type         xlate;
   ring_status_type   status;
   logic [CHAR_W-1:0] rdata;

   logic              valid_ff;
   logic              is_pop_ff;
   logic              out_valid_ff;
   logic              empty_ff;
   logic [CHAR_W-1:0] echo_ff;

   assign req_ready = !valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   scta_xlate u_xlate (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .opcode   (req_opcode),
      .scancode (req_scancode),
      .xlate    (xlate)
   );

   scta_ring u_ring (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .opcode (req_opcode),
      .xlate  (xlate),
      .status (status),
      .rdata  (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         is_pop_ff    <= status.pop;
         out_valid_ff <= xlate.push || status.pop;
         empty_ff     <= status.empty_next;
         echo_ff      <= xlate.push ? xlate.ch : '0;
      end
   end

   // popped data comes straight from the buffer's read register
   assign rsp_valid        = valid_ff;
   assign rsp_out_char     = is_pop_ff ? rdata : echo_ff;
   assign rsp_out_valid    = out_valid_ff;
   assign rsp_buffer_empty = empty_ff;

   `SCTA_ASSERT_NOW(a_stall_means_pending, !req_ready, rsp_valid)
   `SCTA_ASSERT_NOW(a_char_flag_match, rsp_valid && !is_pop_ff,
                    rsp_out_valid == (rsp_out_char != '0))
   `SCTA_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_out_char) && $stable(rsp_buffer_empty))

endmodule
